>>> hdl/twl_pkg.sv
package twl_pkg;

	// Line geometry and number format
	localparam int MAX_TIME  = 16;
	localparam int FRAC_BITS = 30;
	localparam int ROWS      = 3 * MAX_TIME;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int CNT_W     = $clog2(ROWS + 1);
	localparam int SLICE_W   = $clog2(MAX_TIME);
	localparam int TS_W      = $clog2(MAX_TIME + 1);
	localparam int ACC_W     = 68;
	localparam int QUEUE_DEPTH = 2;

	// line_mode codes
	localparam logic [1:0] MODE_SHORT = 2'd0;
	localparam logic [1:0] MODE_FWD   = 2'd1;
	localparam logic [1:0] MODE_BWD   = 2'd2;

	// register indexes (paddr[2])
	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_EXTENT = 1'b1;

	localparam logic signed [31:0] Q_ONE = 32'(64'd1 << FRAC_BITS);

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cplx_t;

	typedef cplx_t [2:0] row_t;

	// one stored link row, queued from front to back
	typedef struct packed {
		row_t              data;
		logic [ROW_W-1:0]  row;
		logic              last;
		logic [TS_W-1:0]   extent;
		logic [1:0]        mode;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	typedef struct packed {
		logic               strobe;
		logic [SLICE_W-1:0] slice;
		logic [1:0]         row;
		row_t               data;
		logic               last;
	} result_t;

	function automatic logic [ROW_W-1:0] row_addr(input logic [SLICE_W-1:0] s,
		input logic [1:0] x);
		row_addr = ROW_W'(3 * int'(s) + int'(x));
	endfunction

endpackage

>>> hdl/twl_front.sv
module twl_front
	import twl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  row_t        in_row,
	input  logic [1:0]  line_mode,
	input  logic [4:0]  time_extent,
	input  logic        queue_full,
	input  logic        line_done,
	output push_t       push
);

	logic [CNT_W-1:0] rows_q;
	logic             pending_q;
	logic [4:0]       ext;
	logic [CNT_W-1:0] idx;
	logic [CNT_W:0]   next_cnt;
	logic [CNT_W:0]   thr;
	logic             accept;
	logic             last;

	// clamp extent to the supported range
	always_comb begin
		ext = time_extent;
		if (ext < 5'd2) ext = 5'd2;
		if (ext > 5'(MAX_TIME)) ext = 5'(MAX_TIME);
	end

	assign busy     = pending_q | queue_full;
	assign accept   = start & ~busy;
	assign idx      = (rows_q >= CNT_W'(ROWS)) ? CNT_W'(ROWS - 1) : rows_q;
	assign next_cnt = {1'b0, idx} + 1'b1;
	assign thr      = (CNT_W+1)'(3 * int'(ext));
	assign last     = next_cnt >= thr;

	always_comb begin
		push.valid       = accept;
		push.job.data    = in_row;
		push.job.row     = idx[ROW_W-1:0];
		push.job.last    = last;
		push.job.extent  = TS_W'(ext);
		push.job.mode    = line_mode;
	end

	// row count and line-in-flight flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= '0;
			pending_q <= 1'b0;
		end else begin
			if (accept) rows_q <= last ? '0 : next_cnt[CNT_W-1:0];
			if (accept && last) pending_q <= 1'b1;
			else if (line_done) pending_q <= 1'b0;
		end
	end

endmodule

>>> hdl/twl_queue.sv
module twl_queue
	import twl_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
)(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  full,
	output logic  not_empty,
	output job_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t           mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full      = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_push   = push.valid & ~full;
	assign do_pop    = pop & not_empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push.job;
	end

	// pointers wrap at DEPTH
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hdl/twl_back.sv
module twl_back
	import twl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_pop,
	output logic    line_done,
	output result_t result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROD  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	// memories: links, forward and backward products, one row per word
	row_t link_mem [ROWS];
	row_t fwd_mem  [ROWS];
	row_t bwd_mem  [ROWS];

	logic [1:0]         state_q;
	logic [1:0]         i_q, j_q, k_q, drain_q, or_q;
	logic [SLICE_W-1:0] t_q, ot_q;
	logic               dir_q;
	logic [TS_W-1:0]    ext_q;
	logic [1:0]         mode_q;

	logic [TS_W-1:0]    ext_m1;
	logic [SLICE_W-1:0] last_slice;
	logic [ROW_W-1:0]   lnk_addr, prod_addr, wr_addr;
	logic [1:0]         col_a;
	logic               ident_b;
	logic               issue;
	logic               out_issue;
	logic               out_last;

	// stage 1: read data and tags
	row_t               lnk_s1, fwd_s1, bwd_s1;
	logic               v_s1, conj_s1, ident_s1, dir_s1, first_s1, fin_s1;
	logic [1:0]         ca_s1, j_s1, k_s1;
	logic [ROW_W-1:0]   wa_s1;
	logic               ov_s1, oid_s1, obwd_s1, olast_s1;
	logic [SLICE_W-1:0] ot_s1;
	logic [1:0]         or_s1;

	// stage 2: partial products
	logic signed [63:0] prr_s2, pii_s2, pri_s2, pir_s2;
	logic               v_s2, dir_s2, first_s2, fin_s2;
	logic [1:0]         j_s2;
	logic [ROW_W-1:0]   wa_s2;

	// stage 3: accumulators
	logic signed [ACC_W-1:0] acc_re_s3, acc_im_s3;
	logic               v_s3, dir_s3, fin_s3;
	logic [1:0]         j_s3;
	logic [ROW_W-1:0]   wa_s3;
	cplx_t              rowbuf_q [2];

	cplx_t              a, b;
	row_t               brow;
	logic signed [ACC_W-1:0] term_re, term_im;
	cplx_t              entry;
	row_t               wr_row;
	logic               wr_en;

	function automatic logic signed [31:0] finish(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		r  = (v + ACC_W'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		hi = ACC_W'(32'sh7fffffff);
		lo = $signed({{(ACC_W-32){1'b1}}, 32'h80000000});
		if (r > hi) finish = 32'sh7fffffff;
		else if (r < lo) finish = 32'sh80000000;
		else finish = r[31:0];
	endfunction

	assign ext_m1     = ext_q - 1'b1;
	assign last_slice = ext_m1[SLICE_W-1:0];
	assign job_pop    = (state_q == ST_IDLE) && job_valid;
	assign issue      = state_q == ST_PROD;
	assign out_issue  = state_q == ST_OUT;
	assign out_last   = (ot_q == last_slice) && (or_q == 2'd2);
	assign line_done  = out_issue && out_last;

	// step addressing: forward uses dagger of link t-1, backward link t
	always_comb begin
		if (dir_q) begin
			lnk_addr  = row_addr(t_q, i_q);
			col_a     = k_q;
			ident_b   = t_q == last_slice;
			prod_addr = row_addr(t_q + 1'b1, k_q);
		end else begin
			lnk_addr  = row_addr(t_q - 1'b1, k_q);
			col_a     = i_q;
			ident_b   = t_q == SLICE_W'(1);
			prod_addr = row_addr(t_q - 1'b1, k_q);
		end
		if (out_issue) prod_addr = row_addr(ot_q, or_q);
		wr_addr = row_addr(t_q, i_q);
	end

	// memory writes and registered memory reads
	always_ff @(posedge clk) begin
		if (job_pop) link_mem[job.row] <= job.data;
		if (wr_en && !dir_s3) fwd_mem[wa_s3] <= wr_row;
		if (wr_en && dir_s3)  bwd_mem[wa_s3] <= wr_row;
		lnk_s1 <= link_mem[lnk_addr];
		fwd_s1 <= fwd_mem[prod_addr];
		bwd_s1 <= bwd_mem[prod_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0; drain_q <= '0;
			t_q <= '0; ot_q <= '0; or_q <= '0;
			dir_q <= 1'b0; ext_q <= TS_W'(MAX_TIME); mode_q <= MODE_SHORT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop && job.last) begin
						state_q <= ST_PROD;
						ext_q   <= job.extent;
						mode_q  <= job.mode;
						dir_q   <= 1'b0;
						t_q     <= SLICE_W'(1);
						i_q <= '0; j_q <= '0; k_q <= '0;
					end
				end
				ST_PROD: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 1'b1;
					if (k_q == 2'd2) begin
						j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 1'b1;
						if (j_q == 2'd2) begin
							i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 1'b1;
							if (i_q == 2'd2) begin
								state_q <= ST_DRAIN;
								drain_q <= '0;
							end
						end
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) begin
						state_q <= ST_PROD;
						if (!dir_q) begin
							if (t_q == last_slice) dir_q <= 1'b1;
							else t_q <= t_q + 1'b1;
						end else if (t_q == '0) begin
							state_q <= ST_OUT;
							ot_q <= '0;
							or_q <= '0;
						end else begin
							t_q <= t_q - 1'b1;
						end
					end
				end
				ST_OUT: begin
					or_q <= (or_q == 2'd2) ? 2'd0 : or_q + 1'b1;
					if (or_q == 2'd2) ot_q <= ot_q + 1'b1;
					if (out_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stage 1 tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			ov_s1 <= 1'b0;
		end else begin
			v_s1  <= issue;
			ov_s1 <= out_issue;
		end
	end

	always_ff @(posedge clk) begin
		conj_s1  <= ~dir_q;
		ident_s1 <= ident_b;
		dir_s1   <= dir_q;
		first_s1 <= k_q == 2'd0;
		fin_s1   <= k_q == 2'd2;
		ca_s1    <= col_a;
		j_s1     <= j_q;
		k_s1     <= k_q;
		wa_s1    <= wr_addr;
		ot_s1    <= ot_q;
		or_s1    <= or_q;
		olast_s1 <= out_last;
		oid_s1   <= (mode_q != MODE_BWD) && (ot_q == '0);
		if (mode_q == MODE_BWD) obwd_s1 <= 1'b1;
		else if (mode_q == MODE_FWD) obwd_s1 <= 1'b0;
		else obwd_s1 <= !((TS_W'(ot_q) + 1'b1) <= (ext_q >> 1));
	end

	// operand select and multiply
	always_comb begin
		a = lnk_s1[ca_s1];
		if (conj_s1) a.im = (a.im == 32'sh80000000) ? 32'sh7fffffff : -a.im;
		brow = dir_s1 ? bwd_s1 : fwd_s1;
		if (ident_s1) begin
			b.re = (k_s1 == j_s1) ? Q_ONE : 32'sd0;
			b.im = 32'sd0;
		end else begin
			b = brow[j_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		prr_s2   <= a.re * b.re;
		pii_s2   <= a.im * b.im;
		pri_s2   <= a.re * b.im;
		pir_s2   <= a.im * b.re;
		dir_s2   <= dir_s1;
		first_s2 <= first_s1;
		fin_s2   <= fin_s1;
		j_s2     <= j_s1;
		wa_s2    <= wa_s1;
	end

	// accumulate one k term per step
	assign term_re = ACC_W'(prr_s2) - ACC_W'(pii_s2);
	assign term_im = ACC_W'(pri_s2) + ACC_W'(pir_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_re_s3 <= first_s2 ? term_re : acc_re_s3 + term_re;
			acc_im_s3 <= first_s2 ? term_im : acc_im_s3 + term_im;
		end
		dir_s3 <= dir_s2;
		fin_s3 <= fin_s2;
		j_s3   <= j_s2;
		wa_s3  <= wa_s2;
	end

	// round, saturate, assemble a row and write it
	assign entry.re = finish(acc_re_s3);
	assign entry.im = finish(acc_im_s3);
	assign wr_en    = v_s3 && fin_s3 && (j_s3 == 2'd2);

	always_comb begin
		wr_row[0] = rowbuf_q[0];
		wr_row[1] = rowbuf_q[1];
		wr_row[2] = entry;
	end

	always_ff @(posedge clk) begin
		if (v_s3 && fin_s3 && j_s3 != 2'd2) rowbuf_q[j_s3[0]] <= entry;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result <= '0;
		end else begin
			result.strobe <= ov_s1;
			result.slice  <= ot_s1;
			result.row    <= or_s1;
			result.last   <= olast_s1;
			for (int c = 0; c < 3; c++) begin
				if (oid_s1) begin
					result.data[c].re <= (2'(c) == or_s1) ? Q_ONE : 32'sd0;
					result.data[c].im <= 32'sd0;
				end else begin
					result.data[c] <= obwd_s1 ? bwd_s1[c] : fwd_s1[c];
				end
			end
		end
	end

endmodule

>>> hdl/temporal_wilson_line_products.sv
// Temporal Wilson line products for one spatial site.
// Input: one link row (three complex Q1.30 entries) per transaction, taken at
// a rising edge with start high and busy low, rows of U(0)..U(T-1) in order.
// Rows that do not finish a line are stored and give no result.
// The row that completes the line (3*T rows, T from time_extent clamped to
// 2..16) starts the product engine: T-1 forward and T backward 3x3 products,
// each 27 complex multiply-accumulate steps plus a pipeline drain; then 3*T
// result rows follow one per cycle, each shown for one cycle with
// result_strobe. The product engine, one complex MAC per cycle, sets the
// line rate; the next line is not taken until this one's results are out.
// busy stays high from the completing row until the last result is issued.
// The receiver cannot stall; results must be taken as they appear.
// Configuration: APB, line_mode at 0x0, time_extent at 0x4, pready always
// high; write only while idle.
// Reset clears the row count, the queue and the sequencer; line_mode resets
// to shortest path and time_extent to 16.
module temporal_wilson_line_products
	import twl_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] entry0_real,
	input  logic signed [31:0] entry0_imag,
	input  logic signed [31:0] entry1_real,
	input  logic signed [31:0] entry1_imag,
	input  logic signed [31:0] entry2_real,
	input  logic signed [31:0] entry2_imag,
	output logic               result_strobe,
	output logic [3:0]         time_slice,
	output logic [1:0]         matrix_row,
	output logic signed [31:0] out0_real,
	output logic signed [31:0] out0_imag,
	output logic signed [31:0] out1_real,
	output logic signed [31:0] out1_imag,
	output logic signed [31:0] out2_real,
	output logic signed [31:0] out2_imag,
	output logic               last_of_line
);

	logic [1:0] line_mode_q;
	logic [4:0] time_extent_q;
	row_t       in_row;
	push_t      push;
	logic       queue_full, job_valid, job_pop, line_done;
	job_t       head;
	result_t    result;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q   <= MODE_SHORT;
			time_extent_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MODE:   line_mode_q   <= pwdata[1:0];
				REG_EXTENT: time_extent_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:   prdata = {30'd0, line_mode_q};
			REG_EXTENT: prdata = {27'd0, time_extent_q};
			default:    prdata = '0;
		endcase
	end

	assign in_row[0] = '{re: entry0_real, im: entry0_imag};
	assign in_row[1] = '{re: entry1_real, im: entry1_imag};
	assign in_row[2] = '{re: entry2_real, im: entry2_imag};

	twl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.in_row      (in_row),
		.line_mode   (line_mode_q),
		.time_extent (time_extent_q),
		.queue_full  (queue_full),
		.line_done   (line_done),
		.push        (push)
	);

	twl_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (job_pop),
		.full      (queue_full),
		.not_empty (job_valid),
		.head      (head)
	);

	twl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (head),
		.job_pop   (job_pop),
		.line_done (line_done),
		.result    (result)
	);

	// result ports
	assign result_strobe = result.strobe;
	assign time_slice    = 4'(result.slice);
	assign matrix_row    = result.row;
	assign out0_real     = result.data[0].re;
	assign out0_imag     = result.data[0].im;
	assign out1_real     = result.data[1].re;
	assign out1_imag     = result.data[1].im;
	assign out2_real     = result.data[2].re;
	assign out2_imag     = result.data[2].im;
	assign last_of_line  = result.last;

endmodule

>>> tb/sv/tb_top.sv
module tb_top
	import twl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [31:0] mat9_t [9];
	typedef logic [5:0][31:0] link_row_t;

	typedef struct {
		logic [3:0]         slice;
		logic [1:0]         row;
		logic signed [31:0] re [3];
		logic signed [31:0] im [3];
		logic               last;
	} line_row_t;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic signed [31:0] S_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S_MIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] entry0_real = '0, entry0_imag = '0, entry1_real = '0;
	logic signed [31:0] entry1_imag = '0, entry2_real = '0, entry2_imag = '0;
	logic result_strobe;
	logic [3:0] time_slice;
	logic [1:0] matrix_row;
	logic signed [31:0] out0_real, out0_imag, out1_real, out1_imag, out2_real, out2_imag;
	logic last_of_line;

	temporal_wilson_line_products i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.entry0_real(entry0_real), .entry0_imag(entry0_imag),
		.entry1_real(entry1_real), .entry1_imag(entry1_imag),
		.entry2_real(entry2_real), .entry2_imag(entry2_imag),
		.result_strobe(result_strobe), .time_slice(time_slice), .matrix_row(matrix_row),
		.out0_real(out0_real), .out0_imag(out0_imag),
		.out1_real(out1_real), .out1_imag(out1_imag),
		.out2_real(out2_real), .out2_imag(out2_imag),
		.last_of_line(last_of_line)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow state of the line engine
	logic signed [31:0] link_re [144], link_im [144];
	logic [1:0] mode_shadow = MODE_SHORT;
	logic [4:0] extent_shadow = 5'd16;
	int unsigned rows_held = 0;

	link_row_t pending_rows [$];
	line_row_t expected_rows [$];
	int errors = 0;
	int unsigned cycle_count = 0;
	int unsigned rows_sent = 0;
	logic no_gaps = 1'b0;

	// round half up, floor, saturate to 32 bits
	function automatic logic signed [31:0] round_sat(input logic signed [127:0] acc);
		logic signed [127:0] v;
		v = (acc + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (v > 128'sd2147483647) return S_MAX;
		if (v < -128'sd2147483648) return S_MIN;
		return v[31:0];
	endfunction

	task automatic mul3(input mat9_t ar, input mat9_t ai, input mat9_t br, input mat9_t bi,
		output mat9_t cr, output mat9_t ci);
		logic signed [127:0] sr, sm;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				sr = '0;
				sm = '0;
				for (int k = 0; k < 3; k++) begin
					sr = sr + ar[i*3+k] * br[k*3+j] - ai[i*3+k] * bi[k*3+j];
					sm = sm + ar[i*3+k] * bi[k*3+j] + ai[i*3+k] * br[k*3+j];
				end
				cr[i*3+j] = round_sat(sr);
				ci[i*3+j] = round_sat(sm);
			end
	endtask

	// conjugate transpose of link t, imaginary -2^31 saturates on negation
	task automatic dagger_link(input int t, output mat9_t dr, output mat9_t di);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				dr[i*3+j] = link_re[t*9 + j*3 + i];
				di[i*3+j] = (link_im[t*9 + j*3 + i] == S_MIN) ? S_MAX :
					-link_im[t*9 + j*3 + i];
			end
	endtask

	// store one row; on line completion queue the 3*T expected rows
	task automatic take_link_row(input link_row_t d);
		int unsigned tc, idx;
		mat9_t fwr [16], fwi [16], bwr [16], bwi [16], ur, ui, dr, di;
		logic ident, use_fwd;
		line_row_t lr;
		tc = (extent_shadow < 2) ? 2 : (extent_shadow > MAX_TIME) ? MAX_TIME : extent_shadow;
		idx = (rows_held >= ROWS) ? ROWS - 1 : rows_held;
		for (int c = 0; c < 3; c++) begin
			link_re[idx*3 + c] = d[2*c];
			link_im[idx*3 + c] = d[2*c+1];
		end
		rows_held = idx + 1;
		if (rows_held < 3 * tc) return;
		rows_held = 0;
		dagger_link(0, fwr[1], fwi[1]);
		for (int t = 2; t < tc; t++) begin
			dagger_link(t - 1, dr, di);
			mul3(dr, di, fwr[t-1], fwi[t-1], fwr[t], fwi[t]);
		end
		for (int e = 0; e < 9; e++) begin
			bwr[tc-1][e] = link_re[(tc-1)*9 + e];
			bwi[tc-1][e] = link_im[(tc-1)*9 + e];
		end
		for (int t = tc - 2; t >= 0; t--) begin
			for (int e = 0; e < 9; e++) begin
				ur[e] = link_re[t*9 + e];
				ui[e] = link_im[t*9 + e];
			end
			mul3(ur, ui, bwr[t+1], bwi[t+1], bwr[t], bwi[t]);
		end
		for (int t = 0; t < tc; t++) begin
			if (mode_shadow == MODE_BWD) begin
				ident = 1'b0;
				use_fwd = 1'b0;
			end else if (mode_shadow == MODE_FWD) begin
				ident = (t == 0);
				use_fwd = 1'b1;
			end else begin
				ident = (t == 0);
				use_fwd = (t + 1 <= tc / 2);
			end
			for (int r = 0; r < 3; r++) begin
				lr.slice = t[3:0];
				lr.row = r[1:0];
				for (int c = 0; c < 3; c++) begin
					if (ident) begin
						lr.re[c] = (c == r) ? Q_ONE : 32'sd0;
						lr.im[c] = 32'sd0;
					end else if (use_fwd) begin
						lr.re[c] = fwr[t][r*3+c];
						lr.im[c] = fwi[t][r*3+c];
					end else begin
						lr.re[c] = bwr[t][r*3+c];
						lr.im[c] = bwi[t][r*3+c];
					end
				end
				lr.last = (t == tc - 1 && r == 2);
				expected_rows.push_back(lr);
			end
		end
	endtask

	// row driver: hold a presented row until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				take_link_row(pending_rows.pop_front());
				rows_sent++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending_rows.size() != 0 &&
				(no_gaps || $urandom_range(0, 99) >= 29)) begin
				start <= 1'b1;
				entry0_real <= pending_rows[0][0];
				entry0_imag <= pending_rows[0][1];
				entry1_real <= pending_rows[0][2];
				entry1_imag <= pending_rows[0][3];
				entry2_real <= pending_rows[0][4];
				entry2_imag <= pending_rows[0][5];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		line_row_t x;
		if (arst_n && result_strobe) begin
			if (expected_rows.size() == 0) begin
				$error("unexpected result transaction slice %0d row %0d", time_slice, matrix_row);
				errors++;
			end else begin
				x = expected_rows.pop_front();
				if (time_slice !== x.slice) begin
					$error("time_slice exp %0d got %0d", x.slice, time_slice); errors++;
				end
				if (matrix_row !== x.row) begin
					$error("matrix_row exp %0d got %0d", x.row, matrix_row); errors++;
				end
				if (out0_real !== x.re[0]) begin
					$error("out0_real exp %0d got %0d", x.re[0], out0_real); errors++;
				end
				if (out0_imag !== x.im[0]) begin
					$error("out0_imag exp %0d got %0d", x.im[0], out0_imag); errors++;
				end
				if (out1_real !== x.re[1]) begin
					$error("out1_real exp %0d got %0d", x.re[1], out1_real); errors++;
				end
				if (out1_imag !== x.im[1]) begin
					$error("out1_imag exp %0d got %0d", x.im[1], out1_imag); errors++;
				end
				if (out2_real !== x.re[2]) begin
					$error("out2_real exp %0d got %0d", x.re[2], out2_real); errors++;
				end
				if (out2_imag !== x.im[2]) begin
					$error("out2_imag exp %0d got %0d", x.im[2], out2_imag); errors++;
				end
				if (last_of_line !== x.last) begin
					$error("last_of_line exp %0d got %0d", x.last, last_of_line); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic apb_write(input logic idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MODE) mode_shadow = value[1:0];
		else extent_shadow = value[4:0];
	endtask

	// wait until all rows are taken and all results are out
	task automatic drain();
		while (pending_rows.size() != 0 || expected_rows.size() != 0 || busy || start)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return S_MIN;
			1: return S_MAX;
			2: return 32'd0;
			3: return Q_ONE;
			4: return -Q_ONE;
			default: return $urandom();
		endcase
	endfunction

	function automatic link_row_t pick_row();
		link_row_t d;
		for (int i = 0; i < 6; i++) d[i] = pick_value();
		return d;
	endfunction

	task automatic queue_rows(input int n);
		for (int i = 0; i < n; i++) pending_rows.push_back(pick_row());
	endtask

	function automatic int unsigned clamp_t(input logic [4:0] e);
		return (e < 2) ? 2 : (e > MAX_TIME) ? MAX_TIME : e;
	endfunction

	initial begin
		link_row_t d;
		int unsigned tc, k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extremes at T=2, shortest path
		apb_write(REG_EXTENT, 32'd2);
		apb_write(REG_MODE, MODE_SHORT);
		d = {6{S_MIN}};
		pending_rows.push_back(d);
		d = {6{S_MAX}};
		pending_rows.push_back(d);
		d = '0;
		pending_rows.push_back(d);
		d = {S_MIN, 32'd0, S_MIN, 32'd0, S_MIN, Q_ONE};
		pending_rows.push_back(d);
		d = {6{Q_ONE}};
		pending_rows.push_back(d);
		d = {6{-Q_ONE}};
		pending_rows.push_back(d);
		drain();

		// forward only, T=3
		apb_write(REG_MODE, MODE_FWD);
		apb_write(REG_EXTENT, 32'd3);
		queue_rows(9);
		drain();

		// backward only; extent below range clamps to 2
		apb_write(REG_MODE, MODE_BWD);
		apb_write(REG_EXTENT, 32'd0);
		queue_rows(6);
		drain();

		// unused mode code acts as shortest; extent lowered mid line
		apb_write(REG_MODE, 32'd3);
		apb_write(REG_EXTENT, 32'd4);
		queue_rows(7);
		drain();
		apb_write(REG_EXTENT, 32'd1);
		queue_rows(1);
		drain();

		// random lines
		k = 0;
		while (rows_sent < 480) begin
			no_gaps = (k >= 6 && k < 12);
			apb_write(REG_MODE, $urandom_range(0, 3));
			if ($urandom_range(0, 7) == 0) apb_write(REG_EXTENT, $urandom_range(0, 31));
			else apb_write(REG_EXTENT, $urandom_range(2, 6));
			tc = clamp_t(extent_shadow);
			if ($urandom_range(0, 5) == 0) begin
				// broken line: change extent partway
				queue_rows($urandom_range(1, 3 * tc - 1));
				drain();
				apb_write(REG_EXTENT, $urandom_range(0, 8));
				tc = clamp_t(extent_shadow);
				queue_rows(rows_held >= 3 * tc ? 1 : 3 * tc - rows_held);
			end else begin
				queue_rows(3 * tc * $urandom_range(1, 3));
			end
			drain();
			k++;
		end
		no_gaps = 1'b0;

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
